/* hw/rtl/pcs_pkg.sv */
// Shared constants, types and state encoding for the prime count sieve.
package pcs_pkg;

  // Largest limit that the flag memory covers.
  localparam int unsigned MAX_LIMIT = 65535;
  localparam int unsigned ADDR_W    = $clog2(MAX_LIMIT + 1);
  // Multiple index holds one extra bit so that an add of the step cannot wrap.
  localparam int unsigned MI_W      = ADDR_W + 1;

  // Fixed field widths of the item channels.
  localparam int unsigned LIMIT_W   = 16;
  localparam int unsigned COUNT_W   = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // First index that takes part in the sieve.
  localparam logic [ADDR_W-1:0] FIRST_IDX = ADDR_W'(2);

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_CAND,
    S_CHK,
    S_CLR,
    S_COUNT,
    S_DRAIN,
    S_DONE
  } pcs_state_t;

  // One access request to the flag memory.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic              wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } pcs_mem_req_t;

endpackage

/* hw/rtl/prime_count_sieve.sv */
// Top level of the prime count sieve: flag memory, sequencer and output register.
// Each item carries a limit and yields one item with the number of primes in
// 2..limit. A limit below two gives zero and goes straight to the result, which
// is loaded into the output register when that register is free. Otherwise the
// sequencer sets every flag from two up to the limit, then runs the mark pass:
// each candidate whose square is within the limit is read, and if still flagged
// its multiples are cleared one by one. It then reads and counts the flags,
// drains the last read and hands over the result. All of it is bound by the
// single write port and single read port of the flag memory. A full output
// register that is not being read holds the result back until it empties. One item
// is worked on at a time, and the next one is taken while the previous result waits
// in the output register.
module prime_count_sieve import pcs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [LIMIT_W-1:0] limit,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [COUNT_W-1:0] num_primes
);

  pcs_mem_req_t       mreq;
  logic               rd_data;
  logic               res_valid;
  logic               res_ready;
  logic [COUNT_W-1:0] res_count;

  pcs_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .limit     (limit),
    .mreq      (mreq),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res_count (res_count),
    .res_ready (res_ready)
  );

  pcs_flag_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (1)
  ) u_flag_ram (
    .clk   (clk),
    .we    (mreq.we),
    .waddr (mreq.waddr),
    .wdata (mreq.wdata),
    .re    (mreq.re),
    .raddr (mreq.raddr),
    .rdata (rd_data)
  );

  // Output register: takes a result whenever it is empty or being emptied.
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      num_primes <= res_count;
    end
  end

  // Flags zero and one are never written.
  assert property (@(posedge clk) disable iff (rst)
    mreq.we |-> (mreq.waddr >= FIRST_IDX))
    else $error("flag write below index two");

  // No memory access while waiting for an item.
  assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (!mreq.we && !mreq.re))
    else $error("flag memory accessed while idle");

  // A limit below two gives a zero result in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (limit < LIMIT_W'(2))) |=>
      (res_valid && (res_count == '0)))
    else $error("small limit did not give zero");

  // A new result is never offered while an item is being accepted.
  assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !res_valid)
    else $error("result offered while idle");

endmodule

/* hw/rtl/pcs_flag_ram.sv */
// Simple dual-port RAM with one write port and one registered read port.
module pcs_flag_ram #(
  parameter int unsigned ADDR_W = 16,
  parameter int unsigned DATA_W = 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/pcs_seq.sv */
// Sequencer that runs the fill, mark and count passes over the flag memory.
module pcs_seq import pcs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [LIMIT_W-1:0] limit,
  output pcs_mem_req_t       mreq,
  input  logic               rd_data,
  output logic               res_valid,
  output logic [COUNT_W-1:0] res_count,
  input  logic               res_ready
);

  pcs_state_t state, state_next;

  logic [ADDR_W-1:0]   lim, lim_next;
  logic [ADDR_W-1:0]   idx, idx_next;
  logic [ADDR_W-1:0]   p, p_next;
  logic [MI_W-1:0]     mi, mi_next;
  logic [COUNT_W-1:0]  cnt, cnt_next;
  logic                rd_vld, rd_vld_next;

  logic [2*ADDR_W-1:0] pp;
  logic [MI_W-1:0]     mi_step;
  logic [ADDR_W-1:0]   lim_sat;

  // Square of the candidate and the next multiple.
  assign pp      = (2*ADDR_W)'(p) * (2*ADDR_W)'(p);
  assign mi_step = mi + MI_W'(p);

  // Limits past the memory saturate to its top entry.
  assign lim_sat = ({1'b0, limit} > (LIMIT_W + 1)'(MAX_LIMIT)) ?
                   ADDR_W'(MAX_LIMIT) : ADDR_W'(limit);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      rd_vld <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= rd_vld_next;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    lim <= lim_next;
    idx <= idx_next;
    p   <= p_next;
    mi  <= mi_next;
    cnt <= cnt_next;
  end

  // Next state, memory requests and datapath updates.
  always_comb begin
    state_next  = state;
    lim_next    = lim;
    idx_next    = idx;
    p_next      = p;
    mi_next     = mi;
    cnt_next    = cnt;
    rd_vld_next = 1'b0;
    mreq        = '0;
    in_ready    = 1'b0;
    res_valid   = 1'b0;

    // Count flags that come back from the count pass, saturating.
    if (rd_vld && rd_data && (cnt != COUNT_MAX)) begin
      cnt_next = cnt + COUNT_W'(1);
    end

    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          lim_next = lim_sat;
          cnt_next = '0;
          idx_next = FIRST_IDX;
          p_next   = FIRST_IDX;
          state_next = (lim_sat < FIRST_IDX) ? S_DONE : S_INIT;
        end
      end
      // Set every flag from two up to the limit.
      S_INIT: begin
        mreq.we    = 1'b1;
        mreq.waddr = idx;
        mreq.wdata = 1'b1;
        idx_next   = idx + ADDR_W'(1);
        if (idx == lim) begin
          state_next = S_CAND;
        end
      end
      // Stop once the square passes the limit, else look up the candidate.
      S_CAND: begin
        if (pp > (2*ADDR_W)'(lim)) begin
          idx_next   = FIRST_IDX;
          state_next = S_COUNT;
        end else begin
          mreq.re    = 1'b1;
          mreq.raddr = p;
          mi_next    = MI_W'(pp);
          state_next = S_CHK;
        end
      end
      // A candidate still flagged is prime and its multiples get cleared.
      S_CHK: begin
        if (rd_data) begin
          state_next = S_CLR;
        end else begin
          p_next     = p + ADDR_W'(1);
          state_next = S_CAND;
        end
      end
      S_CLR: begin
        mreq.we    = 1'b1;
        mreq.waddr = mi[ADDR_W-1:0];
        mreq.wdata = 1'b0;
        mi_next    = mi_step;
        if (mi_step > MI_W'(lim)) begin
          p_next     = p + ADDR_W'(1);
          state_next = S_CAND;
        end
      end
      // Stream reads of every flag; the registered read data is counted as it comes back.
      S_COUNT: begin
        mreq.re     = 1'b1;
        mreq.raddr  = idx;
        rd_vld_next = 1'b1;
        idx_next    = idx + ADDR_W'(1);
        if (idx == lim) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign res_count = cnt;

endmodule
